>>> rtl/fixtde_pkg.sv
package fixtde_pkg;

  // Character codes of the tag and the digit range.
  localparam logic [7:0] CHAR_3     = 8'h33;
  localparam logic [7:0] CHAR_8     = 8'h38;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VOLUME_W = 31;
  localparam int unsigned PHASE_W  = 3;

  // Clamp value of the volume and the reset value of the header length.
  localparam logic [VOLUME_W-1:0] VOLUME_MAX        = '1;
  localparam logic [BYTE_W-1:0]   HEADER_SKIP_RESET = 8'd26;
  localparam logic [BYTE_W-1:0]   POSITION_MAX      = '1;

  // Input item: one frame byte with its end-of-frame mark.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  // Result item: one per frame.
  typedef struct packed {
    logic [VOLUME_W-1:0] volume;
    logic                tag_found;
    logic                saturated;
  } out_item_t;

  // Configuration write data.
  typedef logic [BYTE_W-1:0] cfg_item_t;

endpackage

>>> rtl/fixtde_stream_if.sv
interface fixtde_stream_if #(
  parameter type payload_t = logic [7:0]
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/fix_tag_decimal_extractor_core.sv
// Extracts the decimal value that follows the first "38=" tag after the header of a frame.
//
// in_chan  (sink, payload fixtde_pkg::in_item_t): one frame byte per transfer,
//          last_byte marks the final byte of the frame.
// out_chan (source, payload fixtde_pkg::out_item_t): one result per frame,
//          carrying volume, tag_found and saturated.
// cfg_chan (sink, payload fixtde_pkg::cfg_item_t): writes header_skip, the
//          number of leading frame bytes ignored by the tag search. Always
//          ready; write it only while no frame is in progress.
//
// Throughput is one byte per cycle. A byte is captured in the input register
// and then updates the scan state as it leaves that register; a last byte
// also loads the result register, from which out_chan presents the result.
// The times-ten accumulate and clamp compare are combinational paths.
// Reset clears both pipeline stages and the scan state and sets header_skip
// to 26. When out_chan stalls with a result pending, non-last bytes keep
// flowing; a last byte waits in the input register and in_chan.ready drops
// until the pending result is transferred.
module fix_tag_decimal_extractor_core (
  input  logic                   clk,
  input  logic                   rst_n,
  fixtde_stream_if.sink          in_chan,
  fixtde_stream_if.source        out_chan,
  fixtde_stream_if.sink          cfg_chan
);

  // Match phase codes.
  localparam logic [fixtde_pkg::PHASE_W-1:0] PH_SEARCH = 3'd0;
  localparam logic [fixtde_pkg::PHASE_W-1:0] PH_GOT3   = 3'd1;
  localparam logic [fixtde_pkg::PHASE_W-1:0] PH_GOT38  = 3'd2;
  localparam logic [fixtde_pkg::PHASE_W-1:0] PH_DIGITS = 3'd3;
  localparam logic [fixtde_pkg::PHASE_W-1:0] PH_DONE   = 3'd4;

  logic [fixtde_pkg::BYTE_W-1:0]   header_skip_r;

  logic                            s1_valid_r;
  fixtde_pkg::in_item_t            s1_item_r;

  logic [fixtde_pkg::BYTE_W-1:0]   pos_r, pos_nxt;
  logic [fixtde_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [fixtde_pkg::VOLUME_W-1:0] acc_r, acc_nxt;
  logic                            found_r, found_nxt;
  logic                            clamp_r, clamp_nxt;

  logic                            out_valid_r;
  fixtde_pkg::out_item_t           out_item_r;

  logic                            out_free;
  logic                            s1_adv;
  logic                            in_ready;
  logic                            in_xfer;
  logic                            frame_end;
  logic                            is_digit;
  logic [fixtde_pkg::VOLUME_W+3:0] acc_times10;

  // Handshake control: the result register frees up when taken, the input
  // register moves on unless a last byte meets a full result register.
  assign out_free  = !out_valid_r || out_chan.ready;
  assign s1_adv    = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_xfer   = in_chan.valid && in_ready;
  assign frame_end = s1_adv && s1_item_r.last_byte;

  assign in_chan.ready    = in_ready;
  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= fixtde_pkg::HEADER_SKIP_RESET;
    end else if (cfg_chan.valid) begin
      header_skip_r <= cfg_chan.payload;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_chan.payload;
    end
  end

  // Digit accumulate: value times ten plus the digit, checked for overflow.
  assign is_digit    = s1_item_r.data_byte inside {[fixtde_pkg::CHAR_0:fixtde_pkg::CHAR_9]};
  assign acc_times10 = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                     + {{(fixtde_pkg::VOLUME_W){1'b0}},
                        s1_item_r.data_byte[3:0]};

  // Scan state update for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    found_nxt = found_r;
    clamp_nxt = clamp_r;
    pos_nxt   = (pos_r == fixtde_pkg::POSITION_MAX) ? pos_r : pos_r + 8'd1;
    if (pos_r >= header_skip_r) begin
      case (phase_r)
        PH_SEARCH: begin
          if (s1_item_r.data_byte == fixtde_pkg::CHAR_3) begin
            phase_nxt = PH_GOT3;
          end
        end
        PH_GOT3: begin
          if (s1_item_r.data_byte == fixtde_pkg::CHAR_8) begin
            phase_nxt = PH_GOT38;
          end else if (s1_item_r.data_byte == fixtde_pkg::CHAR_3) begin
            phase_nxt = PH_GOT3;
          end else begin
            phase_nxt = PH_SEARCH;
          end
        end
        PH_GOT38: begin
          if (s1_item_r.data_byte == fixtde_pkg::CHAR_EQUAL) begin
            phase_nxt = PH_DIGITS;
            found_nxt = 1'b1;
          end else if (s1_item_r.data_byte == fixtde_pkg::CHAR_3) begin
            phase_nxt = PH_GOT3;
          end else begin
            phase_nxt = PH_SEARCH;
          end
        end
        PH_DIGITS: begin
          if (!is_digit) begin
            phase_nxt = PH_DONE;
          end else if (acc_times10[fixtde_pkg::VOLUME_W+3:fixtde_pkg::VOLUME_W] != 4'd0) begin
            acc_nxt   = fixtde_pkg::VOLUME_MAX;
            clamp_nxt = 1'b1;
          end else begin
            acc_nxt = acc_times10[fixtde_pkg::VOLUME_W-1:0];
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Scan state registers; the frame end clears them for the next frame.
  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      pos_r   <= '0;
      phase_r <= PH_SEARCH;
      acc_r   <= '0;
      found_r <= 1'b0;
      clamp_r <= 1'b0;
    end else if (s1_adv) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      found_r <= found_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_item_r.volume    <= acc_nxt;
      out_item_r.tag_found <= found_nxt;
      out_item_r.saturated <= clamp_nxt;
    end
  end

  // A clamped result always carries the maximum volume.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.saturated |-> out_item_r.volume == fixtde_pkg::VOLUME_MAX)
    else $error("saturated result without maximum volume");

  // Without a tag there is neither a value nor a clamp.
  a_no_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.tag_found |-> out_item_r.volume == '0 && !out_item_r.saturated)
    else $error("value reported without a tag match");

  // The found flag tracks the phases that follow a match.
  a_found_phase: assert property (@(posedge clk) disable iff (!rst_n)
    found_r == (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("found flag out of step with match phase");

  // The end of a frame leaves the scan state cleared.
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> pos_r == '0 && phase_r == PH_SEARCH && acc_r == '0)
    else $error("scan state not cleared after frame end");

  // Input stalls only for a last byte waiting on a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_item_r.last_byte && out_valid_r && !out_chan.ready)
    else $error("input stalled without a pending result");

endmodule

>>> dv/fix_tag_decimal_extractor_core_test.sv
`timescale 1ns / 100ps

module fix_tag_decimal_extractor_core_test;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned SETTLE     = 4;

  // Scan phases of the predictor.
  typedef enum logic [fixtde_pkg::PHASE_W-1:0] {
    SEEK_3    = 3'd0,
    SEEN_3    = 3'd1,
    SEEN_38   = 3'd2,
    IN_DIGITS = 3'd3,
    RUN_DONE  = 3'd4
  } scan_phase_t;

  // Tracks the frame scan and holds the expected per-frame results.
  class volume_tracker_t;
    logic [fixtde_pkg::BYTE_W-1:0]   header_len;
    logic [fixtde_pkg::BYTE_W-1:0]   position;
    scan_phase_t                     phase;
    logic [fixtde_pkg::VOLUME_W-1:0] value;
    logic                            found;
    logic                            clamped;
    fixtde_pkg::out_item_t           frame_results[$];
    int unsigned                     mismatches;
    int unsigned                     frames_checked;
    int unsigned                     tags_seen;
    int unsigned                     clamps_seen;

    function new();
      header_len     = fixtde_pkg::HEADER_SKIP_RESET;
      mismatches     = 0;
      frames_checked = 0;
      tags_seen      = 0;
      clamps_seen    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      position = '0;
      phase    = SEEK_3;
      value    = '0;
      found    = 1'b0;
      clamped  = 1'b0;
    endfunction

    function void set_header(logic [fixtde_pkg::BYTE_W-1:0] len);
      header_len = len;
    endfunction

    function int unsigned outstanding();
      return frame_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Accumulate one decimal digit, clamping at the largest volume.
    function void add_digit(logic [3:0] d);
      logic [fixtde_pkg::VOLUME_W+3:0] wide;
      wide = {4'b0, value} * 35'd10 + 35'(d);
      if (wide > {4'b0, fixtde_pkg::VOLUME_MAX}) begin
        value   = fixtde_pkg::VOLUME_MAX;
        clamped = 1'b1;
      end else begin
        value = wide[fixtde_pkg::VOLUME_W-1:0];
      end
    endfunction

    function void scan(logic [fixtde_pkg::BYTE_W-1:0] b);
      case (phase)
        SEEK_3: begin
          if (b == fixtde_pkg::CHAR_3) phase = SEEN_3;
        end
        SEEN_3: begin
          if (b == fixtde_pkg::CHAR_8) phase = SEEN_38;
          else if (b == fixtde_pkg::CHAR_3) phase = SEEN_3;
          else phase = SEEK_3;
        end
        SEEN_38: begin
          if (b == fixtde_pkg::CHAR_EQUAL) begin
            phase = IN_DIGITS;
            found = 1'b1;
          end else if (b == fixtde_pkg::CHAR_3) begin
            phase = SEEN_3;
          end else begin
            phase = SEEK_3;
          end
        end
        IN_DIGITS: begin
          if (b >= fixtde_pkg::CHAR_0 && b <= fixtde_pkg::CHAR_9)
            add_digit(4'(b - fixtde_pkg::CHAR_0));
          else phase = RUN_DONE;
        end
        default: begin
        end
      endcase
    endfunction

    // Called for each accepted input byte.
    function void note_byte(fixtde_pkg::in_item_t it);
      fixtde_pkg::out_item_t res;
      if (position >= header_len) scan(it.data_byte);
      if (position != fixtde_pkg::POSITION_MAX) position = position + 1'b1;
      if (it.last_byte) begin
        res.volume    = value;
        res.tag_found = found;
        res.saturated = clamped;
        frame_results.push_back(res);
        clear_frame();
      end
    endfunction

    // Called for each accepted result.
    task check_result(fixtde_pkg::out_item_t got);
      fixtde_pkg::out_item_t want;
      if (frame_results.size() == 0) begin
        report_mismatch($sformatf("result with no frame outstanding: volume %0d", got.volume));
      end else begin
        want = frame_results.pop_front();
        frames_checked++;
        if (want.tag_found) tags_seen++;
        if (want.saturated) clamps_seen++;
        if (got.volume !== want.volume)
          report_mismatch($sformatf("volume %0d, expected %0d", got.volume, want.volume));
        if (got.tag_found !== want.tag_found)
          report_mismatch($sformatf("tag_found %b, expected %b", got.tag_found, want.tag_found));
        if (got.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, expected %b", got.saturated, want.saturated));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  fixtde_stream_if #(.payload_t(fixtde_pkg::in_item_t))  in_if ();
  fixtde_stream_if #(.payload_t(fixtde_pkg::out_item_t)) out_if ();
  fixtde_stream_if #(.payload_t(fixtde_pkg::cfg_item_t)) cfg_if ();

  fix_tag_decimal_extractor_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  volume_tracker_t tracker = new();

  int unsigned                   tx_idle_pct = 0;
  int unsigned                   rx_stall_pct = 0;
  bit                            long_hold = 1'b0;
  int unsigned                   bytes_sent = 0;
  int unsigned                   header_writes = 0;
  logic [fixtde_pkg::BYTE_W-1:0] frame_bytes[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Drive every input to a known value from the start.
  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    out_if.ready   <= 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_hold && held < LONG_HOLD) begin
        out_if.ready <= 1'b0;
        held++;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Observe transfers on both data channels; results are checked first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) tracker.check_result(out_if.payload);
      if (in_if.valid && in_if.ready) tracker.note_byte(in_if.payload);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    int unsigned quiet;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [fixtde_pkg::BYTE_W-1:0] pick_filler();
    logic [fixtde_pkg::BYTE_W-1:0] tag_chars[5] = '{fixtde_pkg::CHAR_3, fixtde_pkg::CHAR_8,
      fixtde_pkg::CHAR_EQUAL, fixtde_pkg::CHAR_0, fixtde_pkg::CHAR_9};
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return tag_chars[$urandom_range(4)];
    if (r < 45) return fixtde_pkg::CHAR_0 + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [fixtde_pkg::BYTE_W-1:0] pick_non_digit();
    logic [fixtde_pkg::BYTE_W-1:0] b;
    do b = 8'($urandom_range(255));
    while (b >= fixtde_pkg::CHAR_0 && b <= fixtde_pkg::CHAR_9);
    return b;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  // One byte transfer, then a random number of idle cycles.
  task automatic send_byte(logic [fixtde_pkg::BYTE_W-1:0] b, logic last);
    fixtde_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Stop offering bytes until every frame result has come back. The first
  // edge lets the monitor note the last byte before the count is read.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_header(logic [fixtde_pkg::BYTE_W-1:0] len);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tracker.set_header(len);
    header_writes++;
  endtask

  // Mostly a well-formed frame: header, tag near the boundary, digits, tail.
  task automatic build_frame(int unsigned hdr);
    int unsigned lead;
    string       volume_edges[2] = '{"2147483647", "2147483648"};
    frame_bytes.delete();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 30)) frame_bytes.push_back(pick_filler());
    end else begin
      lead = hdr + $urandom_range(0, 5);
      if ($urandom_range(99) < 20) lead = (hdr > 3) ? hdr - $urandom_range(1, 3) : 0;
      repeat (lead) frame_bytes.push_back(pick_filler());
      if ($urandom_range(99) < 25) frame_bytes.push_back(fixtde_pkg::CHAR_3);
      frame_bytes.push_back(fixtde_pkg::CHAR_3);
      frame_bytes.push_back(fixtde_pkg::CHAR_8);
      frame_bytes.push_back(fixtde_pkg::CHAR_EQUAL);
      if ($urandom_range(99) < 10) begin
        push_text(volume_edges[$urandom_range(1)]);
      end else begin
        repeat ($urandom_range(0, 12))
          frame_bytes.push_back(fixtde_pkg::CHAR_0 + 8'($urandom_range(9)));
      end
      if ($urandom_range(99) < 50) begin
        frame_bytes.push_back(pick_non_digit());
        repeat ($urandom_range(0, 6)) frame_bytes.push_back(pick_filler());
        if ($urandom_range(99) < 30) push_text("38=9");
      end
    end
  endtask

  task automatic run_phase(logic [fixtde_pkg::BYTE_W-1:0] hdr, int unsigned tx_pct,
                           int unsigned rx_pct, int unsigned frames);
    drain();
    write_header(hdr);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (frames) begin
      build_frame(hdr);
      send_frame();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the reset header length, with a tag straddling its boundary.
    frame_bytes.delete();
    for (int i = 0; i < 24; i++) frame_bytes.push_back((i % 2) ? 8'hFF : 8'h00);
    push_text("38=38=5");
    send_frame();

    // Directed, no header: tag at frame end, overlapping tags, second tag
    // ignored, and a frame that holds only a partial tag.
    drain();
    write_header(8'd0);
    frame_bytes.delete();
    push_text("38=");
    send_frame();
    frame_bytes.delete();
    push_text("3838=12");
    send_frame();
    frame_bytes.delete();
    push_text("338=7;38=9");
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(fixtde_pkg::CHAR_3);
    send_frame();

    // Random phases over header lengths and handshake pressure.
    run_phase(8'd0, 0, 0, 25);
    run_phase(8'd255, 13, 13, 2);
    run_phase(8'($urandom_range(1, 40)), 79, 0, 12);
    run_phase(8'($urandom_range(0, 12)), 0, 79, 15);

    // Receiver holds off while frames keep coming, so the input stalls.
    drain();
    write_header(8'd3);
    tx_idle_pct  = 13;
    rx_stall_pct = 13;
    long_hold    = 1'b1;
    repeat (15) begin
      build_frame(3);
      send_frame();
    end

    run_phase(fixtde_pkg::HEADER_SKIP_RESET, 0, 0, 6);
    run_phase(8'($urandom_range(0, 255)), 13, 13, 1);

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes in %0d frames over %0d header settings.",
             bytes_sent, tracker.frames_checked, header_writes);
    $display("Frames with the tag: %0d, clamped volumes: %0d, mismatches: %0d.",
             tracker.tags_seen, tracker.clamps_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
